[rtl/emulation_prevention_removal_defines.svh]
// Assertion macros shared by the emulation prevention removal RTL.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef EMULATION_PREVENTION_REMOVAL_DEFINES_SVH
`define EMULATION_PREVENTION_REMOVAL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define EPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("epr assertion failed");

// Next-cycle implication, disabled during reset.
`define EPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("epr assertion failed");

`endif

[rtl/epr_pkg.sv]
package epr_pkg;

  localparam int MAX_TRAIL_ZEROS_DEFAULT = 31;
  localparam int COUNT_BITS_DEFAULT = 24;
  localparam int QUEUE_DEPTH = 4;

  // Widest held zero run over the allowed parameter range (up to 63).
  localparam int RUN_W = 6;
  localparam int OUT_COUNT_W = 24;

  localparam logic [7:0] ZERO_BYTE = 8'h00;
  localparam logic [7:0] EPB_BYTE = 8'h03;
  localparam logic [7:0] STOP_BYTE = 8'h80;
  localparam logic [1:0] ZERO_RUN_EPB = 2'd2;
  localparam logic [1:0] ZERO_RUN_SAT = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_STOP = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // One classified item: an optional release of a held stop byte and its
  // zeros, an optional kept byte, and an optional closing result.
  typedef struct packed {
    logic rel;
    logic [RUN_W-1:0] rel_zeros;
    logic keep;
    logic [7:0] byte_val;
    logic fin;
    logic [OUT_COUNT_W-1:0] count;
    logic [1:0] st;
  } epr_cmd_t;

endpackage

[rtl/epr_front.sv]
module epr_front #(
  parameter int MAX_TRAIL_ZEROS = 31,
  parameter int COUNT_BITS = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic [7:0] in_byte,
  input  logic last,
  input  logic cfg_valid,
  input  logic cfg_data,
  input  logic q_full,
  output logic q_push,
  output epr_pkg::epr_cmd_t q_data
);
  import epr_pkg::*;

  localparam int ZCNT_W = $clog2(MAX_TRAIL_ZEROS + 1);

  logic emit_bytes;
  logic held_stop, held_stop_next;
  logic [ZCNT_W-1:0] held_zero_count, held_zero_count_next;
  logic [1:0] zero_run, zero_run_next;
  logic [COUNT_BITS-1:0] kept_count, kept_count_next, kept_sat;
  logic overflow_seen, overflow_seen_next;

  logic accept;
  logic rel, keep;
  logic [ZCNT_W:0] inc;
  logic [COUNT_BITS:0] sum;
  logic [1:0] st;

  assign accept = push && !q_full;

  always_comb begin
    held_stop_next = held_stop;
    held_zero_count_next = held_zero_count;
    zero_run_next = zero_run;
    overflow_seen_next = overflow_seen;
    rel = 1'b0;
    keep = 1'b0;
    if (accept) begin
      if (in_byte == ZERO_BYTE) begin
        if (zero_run != ZERO_RUN_SAT) begin
          zero_run_next = zero_run + 2'd1;
        end
        if (held_stop) begin
          if (held_zero_count < ZCNT_W'(MAX_TRAIL_ZEROS)) begin
            held_zero_count_next = held_zero_count + ZCNT_W'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
        end else begin
          keep = 1'b1;
        end
      end else begin
        rel = held_stop;
        held_stop_next = 1'b0;
        held_zero_count_next = '0;
        zero_run_next = '0;
        if (!(in_byte == EPB_BYTE && zero_run == ZERO_RUN_EPB)) begin
          if (in_byte == STOP_BYTE) begin
            held_stop_next = 1'b1;
          end else begin
            keep = 1'b1;
          end
        end
      end
    end
  end

  // A release keeps the stop byte plus its held zeros.
  always_comb begin
    inc = '0;
    if (rel) begin
      inc = {1'b0, held_zero_count} + (ZCNT_W + 1)'(1);
    end
    if (keep) begin
      inc = inc + (ZCNT_W + 1)'(1);
    end
  end

  assign sum = {1'b0, kept_count} + (COUNT_BITS + 1)'(inc);
  // The count is capped at all ones, so a carry out means saturation.
  assign kept_sat = sum[COUNT_BITS] ? '1 : sum[COUNT_BITS-1:0];

  always_comb begin
    if (overflow_seen_next) begin
      st = ST_OVERFLOW;
    end else if (held_stop_next) begin
      st = ST_OK;
    end else begin
      st = ST_NO_STOP;
    end
  end

  assign kept_count_next = (accept && last) ? '0 : (accept ? kept_sat : kept_count);

  assign q_push = accept && ((emit_bytes && (rel || keep)) || last);

  always_comb begin
    q_data.rel = rel && emit_bytes;
    q_data.rel_zeros = RUN_W'(held_zero_count);
    q_data.keep = keep && emit_bytes;
    q_data.byte_val = in_byte;
    q_data.fin = last;
    q_data.count = OUT_COUNT_W'(kept_sat);
    q_data.st = st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_bytes <= 1'b1;
      held_stop <= 1'b0;
      held_zero_count <= '0;
      zero_run <= '0;
      kept_count <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cfg_valid) begin
        emit_bytes <= cfg_data;
      end
      kept_count <= kept_count_next;
      if (accept && last) begin
        held_stop <= 1'b0;
        held_zero_count <= '0;
        zero_run <= '0;
        overflow_seen <= 1'b0;
      end else begin
        held_stop <= held_stop_next;
        held_zero_count <= held_zero_count_next;
        zero_run <= zero_run_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule

[rtl/epr_queue.sv]
module epr_queue #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  epr_pkg::epr_cmd_t data_in,
  output logic full,
  input  logic pop,
  output logic valid,
  output epr_pkg::epr_cmd_t data_out
);
  import epr_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  epr_cmd_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign valid = (count != '0);
  assign do_push = push && !full;
  assign do_pop = pop && valid;
  assign data_out = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

[rtl/epr_back.sv]
`include "emulation_prevention_removal_defines.svh"

module epr_back #(
  parameter int MAX_TRAIL_ZEROS = 31
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  epr_pkg::epr_cmd_t q_data,
  output logic q_pop,
  output logic empty,
  input  logic pop,
  output logic [7:0] out_byte,
  output logic is_final,
  output logic [epr_pkg::OUT_COUNT_W-1:0] byte_count,
  output logic [1:0] status
);
  import epr_pkg::*;

  localparam int ZCNT_W = $clog2(MAX_TRAIL_ZEROS + 1);

  logic rel_stop, rel_stop_next;
  logic [ZCNT_W-1:0] zeros_left, zeros_left_next;
  logic keep_pend, keep_pend_next;
  logic [7:0] keep_val, keep_val_next;
  logic fin_pend, fin_pend_next;
  logic [OUT_COUNT_W-1:0] fin_count, fin_count_next;
  logic [1:0] fin_st, fin_st_next;

  logic out_valid;
  logic out_free, any_pend, issue, rest, load;
  logic [7:0] beat_byte;
  logic beat_fin;
  logic [OUT_COUNT_W-1:0] beat_count;
  logic [1:0] beat_st;

  assign out_free = !out_valid || pop;
  assign any_pend = rel_stop || (zeros_left != '0) || keep_pend || fin_pend;
  assign issue = any_pend && out_free;

  // Beats leave in order: stop byte, its zeros, the kept byte, the closing beat.
  always_comb begin
    rel_stop_next = rel_stop;
    zeros_left_next = zeros_left;
    keep_pend_next = keep_pend;
    fin_pend_next = fin_pend;
    beat_byte = ZERO_BYTE;
    beat_fin = 1'b0;
    beat_count = '0;
    beat_st = ST_OK;
    if (issue) begin
      if (rel_stop) begin
        beat_byte = STOP_BYTE;
        rel_stop_next = 1'b0;
      end else if (zeros_left != '0) begin
        zeros_left_next = zeros_left - ZCNT_W'(1);
      end else if (keep_pend) begin
        beat_byte = keep_val;
        keep_pend_next = 1'b0;
      end else begin
        beat_fin = 1'b1;
        beat_count = fin_count;
        beat_st = fin_st;
        fin_pend_next = 1'b0;
      end
    end
  end

  assign rest = rel_stop_next || (zeros_left_next != '0) || keep_pend_next || fin_pend_next;
  assign load = q_valid && !rest;
  assign q_pop = load;

  always_comb begin
    keep_val_next = keep_val;
    fin_count_next = fin_count;
    fin_st_next = fin_st;
    if (load) begin
      keep_val_next = q_data.byte_val;
      fin_count_next = q_data.count;
      fin_st_next = q_data.st;
    end
  end

  always_ff @(posedge clk) begin
    keep_val <= keep_val_next;
    fin_count <= fin_count_next;
    fin_st <= fin_st_next;
    if (issue) begin
      out_byte <= beat_byte;
      is_final <= beat_fin;
      byte_count <= beat_count;
      status <= beat_st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_stop <= 1'b0;
      zeros_left <= '0;
      keep_pend <= 1'b0;
      fin_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        rel_stop <= q_data.rel;
        zeros_left <= q_data.rel ? ZCNT_W'(q_data.rel_zeros) : '0;
        keep_pend <= q_data.keep;
        fin_pend <= q_data.fin;
      end else begin
        rel_stop <= rel_stop_next;
        zeros_left <= zeros_left_next;
        keep_pend <= keep_pend_next;
        fin_pend <= fin_pend_next;
      end
      if (issue) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty = !out_valid;

  `EPR_ASSERT_NOW(a_zero_cap, 1'b1, zeros_left <= ZCNT_W'(MAX_TRAIL_ZEROS))
  `EPR_ASSERT_NOW(a_final_byte, out_valid && is_final, out_byte == ZERO_BYTE)
  `EPR_ASSERT_NOW(a_byte_fields, out_valid && !is_final, byte_count == '0 && status == ST_OK)
  `EPR_ASSERT_NOW(a_load_valid, q_pop, q_valid && !rest)
  `EPR_ASSERT_NEXT(a_issue_fills, issue, out_valid)

endmodule

[rtl/emulation_prevention_removal.sv]
// Channel   Signals                                         Beat moves when
// input     push, full, in_byte, last                       push && !full
// result    empty, pop, out_byte, is_final, byte_count,     pop && !empty
//           status
// config    cfg_valid, cfg_ready, cfg_data (emit_bytes)     cfg_valid && cfg_ready
//
// The front classifies one input byte per cycle and writes at most one command
// into a four-entry queue. The back turns each command into result beats at one
// beat per cycle while the output is not stalled: a byte that releases a held stop
// byte with N zeros gives N + 2 beats, or N + 1 when that byte is itself dropped or
// held, plus the closing beat on a last byte.
// Input stalls only when the queue is full; result stalls hold the output register.
// Reset is synchronous and active high; it clears all control state and sets
// emit_bytes to 1. Configuration is taken in any cycle.
module emulation_prevention_removal #(
  parameter int MAX_TRAIL_ZEROS = epr_pkg::MAX_TRAIL_ZEROS_DEFAULT,
  parameter int COUNT_BITS = epr_pkg::COUNT_BITS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [7:0] in_byte,
  input  logic last,
  output logic empty,
  input  logic pop,
  output logic [7:0] out_byte,
  output logic is_final,
  output logic [epr_pkg::OUT_COUNT_W-1:0] byte_count,
  output logic [1:0] status,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);
  import epr_pkg::*;

  epr_cmd_t fq_data, bq_data;
  logic q_push, q_full, q_pop, q_valid;

  assign cfg_ready = 1'b1;
  assign full = q_full;

  epr_front #(
    .MAX_TRAIL_ZEROS(MAX_TRAIL_ZEROS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push),
    .in_byte(in_byte),
    .last(last),
    .cfg_valid(cfg_valid && cfg_ready),
    .cfg_data(cfg_data),
    .q_full(q_full),
    .q_push(q_push),
    .q_data(fq_data)
  );

  epr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk(clk),
    .rst(rst),
    .push(q_push),
    .data_in(fq_data),
    .full(q_full),
    .pop(q_pop),
    .valid(q_valid),
    .data_out(bq_data)
  );

  epr_back #(
    .MAX_TRAIL_ZEROS(MAX_TRAIL_ZEROS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .q_valid(q_valid),
    .q_data(bq_data),
    .q_pop(q_pop),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .is_final(is_final),
    .byte_count(byte_count),
    .status(status)
  );

endmodule

[bench/tb_emulation_prevention_removal.sv]
`timescale 1ns / 100ps

module tb_emulation_prevention_removal;
  import epr_pkg::*;

  localparam int MAX_TRAIL = MAX_TRAIL_ZEROS_DEFAULT;
  localparam int unsigned COUNT_CAP = (32'd1 << COUNT_BITS_DEFAULT) - 1;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [7:0] data;
    logic fin;
    logic [OUT_COUNT_W-1:0] cnt;
    logic [1:0] st;
  } beat_t;

  // One stimulus row: a byte sent reps times, last only on the final copy.
  // Where chk is set, the closing beat of that row carries cnt and st.
  typedef struct packed {
    logic [7:0] b;
    logic l;
    int reps;
    logic chk;
    logic [OUT_COUNT_W-1:0] cnt;
    logic [1:0] st;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic [7:0] in_byte = 8'h00;
  logic last = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_byte;
  logic is_final;
  logic [OUT_COUNT_W-1:0] byte_count;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  // Shadow of the remover state.
  logic emit_on = 1'b1;
  logic stop_held = 1'b0;
  int trail_zeros = 0;
  logic [1:0] zrun = 2'd0;
  int unsigned kept = 0;
  logic ovf = 1'b0;

  beat_t out_stream_q[$];
  row_t byte_plan[$];

  logic cur_chk = 1'b0;
  logic [OUT_COUNT_W-1:0] cur_cnt = '0;
  logic [1:0] cur_st = ST_OK;

  int push_skip_pct = 0;
  int pop_skip_pct = 0;
  int pop_hold = 0;

  int n_fail = 0;
  int n_sent = 0;
  int n_beats = 0;
  int n_units = 0;

  row_t dir_rows [0:23] = '{
    '{STOP_BYTE, 1'b1, 1, 1'b1, 24'd0, ST_OK},
    '{8'hFF,     1'b1, 1, 1'b1, 24'd1, ST_NO_STOP},
    '{ZERO_BYTE, 1'b1, 1, 1'b1, 24'd1, ST_NO_STOP},
    // Drop after two zeros, keep after three, drop across a held run.
    '{ZERO_BYTE, 1'b0, 2, 1'b0, 24'd0, ST_OK},
    '{EPB_BYTE,  1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{ZERO_BYTE, 1'b0, 3, 1'b0, 24'd0, ST_OK},
    '{EPB_BYTE,  1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{STOP_BYTE, 1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{ZERO_BYTE, 1'b0, 2, 1'b0, 24'd0, ST_OK},
    '{EPB_BYTE,  1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{STOP_BYTE, 1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{ZERO_BYTE, 1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{STOP_BYTE, 1'b1, 1, 1'b1, 24'd11, ST_OK},
    // Held zero run past the cap, then no stop byte at the end.
    '{STOP_BYTE, 1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{ZERO_BYTE, 1'b0, 33, 1'b0, 24'd0, ST_OK},
    '{8'h7F,     1'b1, 1, 1'b1, 24'd33, ST_OVERFLOW},
    // Regular trailer with zeros after the stop byte.
    '{8'h11,     1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{STOP_BYTE, 1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{ZERO_BYTE, 1'b1, 2, 1'b1, 24'd1, ST_OK},
    // Trailing zeros with no stop byte are kept.
    '{8'hFF,     1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{ZERO_BYTE, 1'b1, 3, 1'b1, 24'd4, ST_NO_STOP},
    '{ZERO_BYTE, 1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{EPB_BYTE,  1'b0, 1, 1'b0, 24'd0, ST_OK},
    '{8'hAA,     1'b1, 1, 1'b1, 24'd3, ST_NO_STOP}
  };

  emulation_prevention_removal i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_byte(in_byte),
    .last(last),
    .empty(empty),
    .pop(pop),
    .out_byte(out_byte),
    .is_final(is_final),
    .byte_count(byte_count),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic beat_t make_beat(logic [7:0] d, logic f, logic [OUT_COUNT_W-1:0] c,
                                      logic [1:0] s);
    beat_t w;
    w.data = d;
    w.fin = f;
    w.cnt = c;
    w.st = s;
    return w;
  endfunction

  function automatic void keep_out(logic [7:0] b);
    if (kept < COUNT_CAP) kept++;
    if (emit_on) out_stream_q.push_back(make_beat(b, 1'b0, '0, ST_OK));
  endfunction

  function automatic void release_stop();
    if (stop_held) begin
      keep_out(STOP_BYTE);
      for (int i = 0; i < trail_zeros; i++) keep_out(ZERO_BYTE);
    end
    stop_held = 1'b0;
    trail_zeros = 0;
  endfunction

  function automatic void strip_step(logic [7:0] b, logic l);
    logic [1:0] st;
    if (b == ZERO_BYTE) begin
      if (zrun != ZERO_RUN_SAT) zrun++;
      if (stop_held) begin
        if (trail_zeros < MAX_TRAIL) trail_zeros++;
        else ovf = 1'b1;
      end else begin
        keep_out(ZERO_BYTE);
      end
    end else if (b == EPB_BYTE && zrun == ZERO_RUN_EPB) begin
      release_stop();
      zrun = 2'd0;
    end else begin
      release_stop();
      zrun = 2'd0;
      if (b == STOP_BYTE) stop_held = 1'b1;
      else keep_out(b);
    end
    if (l) begin
      if (ovf) st = ST_OVERFLOW;
      else if (stop_held) st = ST_OK;
      else st = ST_NO_STOP;
      out_stream_q.push_back(make_beat(ZERO_BYTE, 1'b1, kept[OUT_COUNT_W-1:0], st));
      stop_held = 1'b0;
      trail_zeros = 0;
      zrun = 2'd0;
      kept = 0;
      ovf = 1'b0;
    end
  endfunction

  always @(posedge clk) begin : scoreboard
    beat_t w;
    if (!rst) begin
      if (cfg_valid && cfg_ready) emit_on = cfg_data;
      if (pop && !empty) begin
        n_beats++;
        if (out_stream_q.size() == 0) begin
          $error("result beat with nothing pending: out_byte %h is_final %b",
                 out_byte, is_final);
          n_fail++;
        end else begin
          w = out_stream_q.pop_front();
          if (w.fin) n_units++;
          if (out_byte !== w.data) begin
            $error("out_byte: expected %h, got %h", w.data, out_byte);
            n_fail++;
          end
          if (is_final !== w.fin) begin
            $error("is_final: expected %b, got %b", w.fin, is_final);
            n_fail++;
          end
          if (byte_count !== w.cnt) begin
            $error("byte_count: expected %0d, got %0d", w.cnt, byte_count);
            n_fail++;
          end
          if (status !== w.st) begin
            $error("status: expected %0d, got %0d", w.st, status);
            n_fail++;
          end
        end
      end
      if (push && !full) begin
        n_sent++;
        strip_step(in_byte, last);
        if (cur_chk) begin
          w = out_stream_q.pop_back();
          w.cnt = cur_cnt;
          w.st = cur_st;
          out_stream_q.push_back(w);
        end
      end
    end
  end

  // Result side: random idling, or a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (pop_hold > 0) begin
        pop <= 1'b0;
        pop_hold--;
      end else begin
        pop <= ($urandom_range(99) >= pop_skip_pct);
      end
    end
  end

  task automatic send_byte(logic [7:0] b, logic l, logic chk, logic [OUT_COUNT_W-1:0] c,
                           logic [1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < push_skip_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    cur_chk = chk;
    cur_cnt = c;
    cur_st = s;
    push <= 1'b1;
    in_byte <= b;
    last <= l;
    do @(posedge clk); while (full);
  endtask

  task automatic send_row(row_t r);
    for (int i = 0; i < r.reps; i++)
      send_byte(r.b, r.l && (i == r.reps - 1), r.chk && (i == r.reps - 1), r.cnt, r.st);
  endtask

  task automatic stop_push();
    @(negedge clk);
    push <= 1'b0;
    cur_chk = 1'b0;
  endtask

  task automatic wait_drained();
    while (out_stream_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_emit(logic v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void plan_push(logic [7:0] b);
    row_t r;
    r = '0;
    r.b = b;
    r.reps = 1;
    byte_plan.push_back(r);
  endfunction

  // One coded unit: content biased toward zeros, 0x03 and 0x80, mostly closed
  // by a proper stop byte trailer, sometimes cut off without one.
  function automatic void plan_unit();
    int body;
    int r;
    int tail;
    row_t e;
    body = $urandom_range(0, 10);
    for (int i = 0; i < body; i++) begin
      r = $urandom_range(99);
      if (r < 4) begin
        plan_push(STOP_BYTE);
        repeat ($urandom_range(28, 36)) plan_push(ZERO_BYTE);
      end else if (r < 36) plan_push(ZERO_BYTE);
      else if (r < 52) plan_push(EPB_BYTE);
      else if (r < 64) plan_push(STOP_BYTE);
      else plan_push(8'($urandom_range(255)));
    end
    if ($urandom_range(99) < 70) begin
      plan_push(STOP_BYTE);
      tail = $urandom_range(0, 3);
      repeat (tail) plan_push(ZERO_BYTE);
    end else if (body == 0) begin
      plan_push(8'($urandom_range(255)));
    end
    e = byte_plan.pop_back();
    e.l = 1'b1;
    byte_plan.push_back(e);
  endfunction

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        push_skip_pct = 20;
        pop_skip_pct = 85;
      end
      1: begin
        push_skip_pct = 85;
        pop_skip_pct = 20;
      end
      default: begin
        push_skip_pct = 0;
        pop_skip_pct = 0;
      end
    endcase
  endtask

  task automatic run_phase(logic emit, int mode, int n_bytes, logic squeeze);
    int total;
    wait_drained();
    write_emit(emit);
    set_idling(mode);
    byte_plan.delete();
    while (byte_plan.size() < n_bytes) plan_unit();
    total = byte_plan.size();
    // Hold the result side so the block fills and pushes back.
    if (squeeze) pop_hold = 400;
    for (int i = 0; i < total; i++) begin
      if (squeeze && i == total / 2) begin
        stop_push();
        while (out_stream_q.size() != 0) @(posedge clk);
      end
      send_row(byte_plan[i]);
    end
    stop_push();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_emit(1'b1);
    set_idling(0);
    foreach (dir_rows[i]) send_row(dir_rows[i]);
    stop_push();

    run_phase(1'b0, 0, 62, 1'b0);
    run_phase(1'b1, 0, 62, 1'b0);
    run_phase(1'b0, 1, 62, 1'b0);
    run_phase(1'b1, 1, 62, 1'b0);
    run_phase(1'b1, 2, 62, 1'b1);
    run_phase(1'b0, 2, 62, 1'b0);

    wait_drained();
    $display("sent %0d bytes; checked %0d result beats closing %0d units", n_sent, n_beats,
             n_units);
    $display("covered both emit settings, held zero overflow and back-pressure");
    if (n_fail == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/epr_pkg.sv
rtl/epr_front.sv
rtl/epr_queue.sv
rtl/epr_back.sv
rtl/emulation_prevention_removal.sv
bench/tb_emulation_prevention_removal.sv
